@@ src/byte_self_information_defines.svh @@
`ifndef BYTE_SELF_INFORMATION_DEFINES_SVH
`define BYTE_SELF_INFORMATION_DEFINES_SVH

// same-cycle implication, reset masks it
`define BSI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks it
`define BSI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bsi_pkg.sv @@
`default_nettype none
package bsi_pkg;
	localparam int COUNT_BITS_DEF    = 17;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int GUARD_BITS        = 8;
	localparam int SYMBOLS           = 256;
	localparam int INFO_BITS         = 21;
	localparam logic [INFO_BITS-1:0] INFO_MAX = '1;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_SCAN_S,
		ST_SCAN_T,
		ST_CNT_RD,
		ST_LOG_T,
		ST_LOG_C,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQ
	} lg_state_t;

	typedef struct packed {
		logic       rd_en;
		logic [7:0] rd_addr;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic       clr;
		logic [7:0] chk_addr;
	} hist_req_t;
endpackage
`default_nettype wire

@@ src/bsi_in_if.sv @@
`default_nettype none
interface bsi_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] symbol_byte;

	modport source (output valid, output command, output symbol_byte, input ready);
	modport sink (input valid, input command, input symbol_byte, output ready);
endinterface
`default_nettype wire

@@ src/bsi_out_if.sv @@
`default_nettype none
interface bsi_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  symbol;
	logic [20:0] surprisal;
	logic        is_last;
	logic        none_left;

	modport source (output valid, output symbol, output surprisal,
		output is_last, output none_left, input ready);
	modport sink (input valid, input symbol, input surprisal,
		input is_last, input none_left, output ready);
endinterface
`default_nettype wire

@@ src/bsi_hist_mem.sv @@
`default_nettype none
module bsi_hist_mem #(
	parameter int COUNT_BITS = bsi_pkg::COUNT_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  bsi_pkg::hist_req_t     req,
	input  wire [COUNT_BITS-1:0]   wr_data,
	output logic [COUNT_BITS-1:0]  rd_data,
	output logic                   chk_hit
);
	logic [COUNT_BITS-1:0] mem [bsi_pkg::SYMBOLS];
	logic [bsi_pkg::SYMBOLS-1:0] valid_q;
	logic [COUNT_BITS-1:0] rd_raw_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;
	assign chk_hit = valid_q[req.chk_addr];
endmodule
`default_nettype wire

@@ src/bsi_log2.sv @@
`default_nettype none
module bsi_log2 #(
	parameter int COUNT_BITS    = bsi_pkg::COUNT_BITS_DEF,
	parameter int FRACTION_BITS = bsi_pkg::FRACTION_BITS_DEF,
	localparam int EB = $clog2(COUNT_BITS),
	localparam int LB = FRACTION_BITS + bsi_pkg::GUARD_BITS,
	localparam int RW = EB + LB
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire [COUNT_BITS-1:0]  x,
	output logic                  done,
	output logic [RW-1:0]         result
);
	localparam int CW = $clog2(LB);

	bsi_pkg::lg_state_t state_q, state_d;
	logic [COUNT_BITS-1:0] w_q;
	logic [EB-1:0]         e_q;
	logic [31:0]           m_q;
	logic [LB-1:0]         frac_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;
	logic [COUNT_BITS+30:0] wide;
	logic [61:0]           prod;
	logic [31:0]           sq;

	assign wide = {w_q, 31'd0};
	assign prod = m_q[30:0] * m_q[30:0];
	assign sq   = prod[61:30];

	always_comb begin
		state_d = state_q;
		case (state_q)
			bsi_pkg::LG_IDLE: begin
				if (start && x != '0) begin
					state_d = bsi_pkg::LG_NORM;
				end
			end
			bsi_pkg::LG_NORM: begin
				if (w_q[COUNT_BITS-1]) begin
					state_d = bsi_pkg::LG_SQ;
				end
			end
			bsi_pkg::LG_SQ: begin
				if (cnt_q == CW'(LB-1)) begin
					state_d = bsi_pkg::LG_IDLE;
				end
			end
			default: state_d = bsi_pkg::LG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsi_pkg::LG_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bsi_pkg::LG_IDLE && start && x == '0) ||
				(state_q == bsi_pkg::LG_SQ && cnt_q == CW'(LB-1));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bsi_pkg::LG_IDLE: begin
				if (start) begin
					w_q    <= x;
					e_q    <= EB'(COUNT_BITS-1);
					frac_q <= '0;
					cnt_q  <= '0;
				end
			end
			bsi_pkg::LG_NORM: begin
				if (w_q[COUNT_BITS-1]) begin
					m_q <= {1'b0, wide[COUNT_BITS+30:COUNT_BITS]};
				end else begin
					w_q <= w_q << 1;
					e_q <= e_q - 1'b1;
				end
			end
			bsi_pkg::LG_SQ: begin
				cnt_q  <= cnt_q + 1'b1;
				frac_q <= {frac_q[LB-2:0], sq[31]};
				m_q    <= sq[31] ? (sq >> 1) : sq;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = (w_q == '0) ? '0 : {e_q, frac_q};
endmodule
`default_nettype wire

@@ src/byte_self_information.sv @@
`default_nettype none
// channel  | dir | fields
// items    | in  | command, symbol_byte
// results  | out | symbol, surprisal, is_last, none_left
//
// Add: histogram read, then write back. Clear: issued on acceptance.
// Read: scans the byte values from the cursor, then two passes of the
// shared log2 unit, one on the total and one on the count.
// Reset empties the histogram at once through per-entry valid bits.
// A result waiting in the output register stalls only the end of the next read.
`include "byte_self_information_defines.svh"
module byte_self_information #(
	parameter int COUNT_BITS    = bsi_pkg::COUNT_BITS_DEF,
	parameter int FRACTION_BITS = bsi_pkg::FRACTION_BITS_DEF
) (
	input wire       clk,
	input wire       arst_n,
	bsi_in_if.sink   items,
	bsi_out_if.source results
);
	localparam int EB = $clog2(COUNT_BITS);
	localparam int RW = EB + FRACTION_BITS + bsi_pkg::GUARD_BITS;
	localparam int GB = bsi_pkg::GUARD_BITS;
	localparam logic [COUNT_BITS-1:0] FULL = '1;

	bsi_pkg::state_t state_q, state_d;
	bsi_pkg::hist_req_t req;
	logic [COUNT_BITS-1:0] rd_data, wr_data, total_q, log_x;
	logic chk_hit, log_start, log_done;
	logic [RW-1:0] log_res, lt_q;
	logic [8:0] cursor_q, scan_q;
	logic [7:0] addr_q, sym_q;
	logic last_q;
	logic out_free, accept;
	logic [RW-1:0] diff;
	logic [RW:0] rsum;
	logic [31:0] rnd;
	logic [bsi_pkg::INFO_BITS-1:0] info;

	logic                          out_valid_q, none_q, is_last_q;
	logic [7:0]                    symbol_q;
	logic [bsi_pkg::INFO_BITS-1:0] info_q;

	assign accept   = items.valid && items.ready;
	assign out_free = !out_valid_q || results.ready;
	assign items.ready = (state_q == bsi_pkg::ST_IDLE);

	bsi_hist_mem #(.COUNT_BITS(COUNT_BITS)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(req), .wr_data(wr_data),
		.rd_data(rd_data), .chk_hit(chk_hit)
	);

	bsi_log2 #(.COUNT_BITS(COUNT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(log_x),
		.done(log_done), .result(log_res)
	);

	assign diff = (lt_q > log_res) ? lt_q - log_res : '0;
	assign rsum = {1'b0, diff} + (RW+1)'(1 << (GB-1));
	assign rnd  = 32'(rsum[RW:GB]);
	assign info = (rnd > 32'(bsi_pkg::INFO_MAX)) ? bsi_pkg::INFO_MAX
		: rnd[bsi_pkg::INFO_BITS-1:0];
	assign wr_data = rd_data + 1'b1;

	always_comb begin
		state_d      = state_q;
		req.rd_en    = 1'b0;
		req.rd_addr  = sym_q;
		req.wr_en    = 1'b0;
		req.wr_addr  = addr_q;
		req.clr      = 1'b0;
		req.chk_addr = scan_q[7:0];
		log_start    = 1'b0;
		log_x        = total_q;
		case (state_q)
			bsi_pkg::ST_IDLE: begin
				if (accept) begin
					case (bsi_pkg::cmd_t'(items.command))
						bsi_pkg::CMD_ADD: begin
							if (items.symbol_byte != 8'd0 && total_q != FULL) begin
								req.rd_en   = 1'b1;
								req.rd_addr = items.symbol_byte;
								state_d     = bsi_pkg::ST_ADD_WR;
							end
						end
						bsi_pkg::CMD_READ:  state_d = bsi_pkg::ST_SCAN_S;
						bsi_pkg::CMD_CLEAR: req.clr = 1'b1;
						default: ;
					endcase
				end
			end
			bsi_pkg::ST_ADD_WR: begin
				req.wr_en = 1'b1;
				state_d   = bsi_pkg::ST_IDLE;
			end
			bsi_pkg::ST_SCAN_S: begin
				if (scan_q[8]) begin
					if (out_free) begin
						state_d = bsi_pkg::ST_IDLE;
					end
				end else if (chk_hit) begin
					state_d = bsi_pkg::ST_SCAN_T;
				end
			end
			bsi_pkg::ST_SCAN_T: begin
				if (scan_q[8] || chk_hit) begin
					state_d = bsi_pkg::ST_CNT_RD;
				end
			end
			bsi_pkg::ST_CNT_RD: begin
				req.rd_en = 1'b1;
				log_start = 1'b1;
				state_d   = bsi_pkg::ST_LOG_T;
			end
			bsi_pkg::ST_LOG_T: begin
				if (log_done) begin
					log_start = 1'b1;
					log_x     = rd_data;
					state_d   = bsi_pkg::ST_LOG_C;
				end
			end
			bsi_pkg::ST_LOG_C: begin
				if (log_done) begin
					state_d = bsi_pkg::ST_FIN;
				end
			end
			bsi_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = bsi_pkg::ST_IDLE;
				end
			end
			default: state_d = bsi_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsi_pkg::ST_IDLE;
			total_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (req.clr) begin
				total_q  <= '0;
				cursor_q <= '0;
			end
			if (req.wr_en) begin
				total_q <= total_q + 1'b1;
			end
			if (state_q == bsi_pkg::ST_SCAN_S && scan_q[8] && out_free) begin
				cursor_q    <= 9'd256;
				out_valid_q <= 1'b1;
			end
			if (state_q == bsi_pkg::ST_FIN && out_free) begin
				cursor_q    <= {1'b0, sym_q} + 9'd1;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= items.symbol_byte;
			scan_q <= cursor_q;
		end
		if (state_q == bsi_pkg::ST_SCAN_S && !scan_q[8]) begin
			scan_q <= scan_q + 1'b1;
			if (chk_hit) begin
				sym_q <= scan_q[7:0];
			end
		end
		if (state_q == bsi_pkg::ST_SCAN_T) begin
			if (scan_q[8] || chk_hit) begin
				last_q <= scan_q[8];
			end else begin
				scan_q <= scan_q + 1'b1;
			end
		end
		if (state_q == bsi_pkg::ST_LOG_T && log_done) begin
			lt_q <= log_res;
		end
		if (state_q == bsi_pkg::ST_SCAN_S && scan_q[8] && out_free) begin
			symbol_q  <= 8'd0;
			info_q    <= '0;
			is_last_q <= 1'b0;
			none_q    <= 1'b1;
		end
		if (state_q == bsi_pkg::ST_FIN && out_free) begin
			symbol_q  <= sym_q;
			info_q    <= info;
			is_last_q <= last_q;
			none_q    <= 1'b0;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.symbol    = symbol_q;
	assign results.surprisal = info_q;
	assign results.is_last   = is_last_q;
	assign results.none_left = none_q;

	`BSI_ASSERT_NEXT(a_clear_empties, req.clr, total_q == '0 && cursor_q == 9'd0,
		"clear left count or cursor")
	`BSI_ASSERT_NOW(a_cursor_range, 1'b1, cursor_q <= 9'd256, "cursor beyond range")
	`BSI_ASSERT_NEXT(a_add_counts, req.wr_en, total_q == $past(total_q) + 1'b1,
		"add did not advance total")
endmodule
`default_nettype wire

@@ verif/bsi_checker.sv @@
`timescale 1ns / 100ps
module bsi_checker (
	input wire  clk,
	input wire  arst_n,
	bsi_in_if   items,
	bsi_out_if  results,
	output int  errors,
	output int  outstanding
);
	localparam int CNT_W = bsi_pkg::COUNT_BITS_DEF;
	localparam int FRAC_W = bsi_pkg::FRACTION_BITS_DEF + bsi_pkg::GUARD_BITS;

	typedef struct {
		logic [7:0]                    symbol;
		logic [bsi_pkg::INFO_BITS-1:0] info;
		logic                          is_last;
		logic                          none_left;
	} symbol_info_t;

	logic [CNT_W-1:0] counts[bsi_pkg::SYMBOLS];
	logic [CNT_W-1:0] total;
	int unsigned      cursor;
	symbol_info_t     info_q[$];

	function automatic longint unsigned log2_fixed(input longint unsigned x);
		int unsigned     top;
		longint unsigned m;
		longint unsigned frac;
		top = 0;
		frac = 0;
		if (x == 0)
			return 0;
		for (int i = 0; i < 64; i++)
			if (x[i])
				top = i;
		m = (top <= 30) ? (x << (30 - top)) : (x >> (top - 30));
		for (int i = 0; i < FRAC_W; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(top) << FRAC_W) | frac;
	endfunction

	function automatic logic [bsi_pkg::INFO_BITS-1:0] info_of(input longint unsigned cnt);
		longint unsigned lt;
		longint unsigned lc;
		longint unsigned d;
		longint unsigned r;
		lt = log2_fixed(total);
		lc = log2_fixed(cnt);
		d = (lt > lc) ? lt - lc : 0;
		r = (d + (64'd1 << (bsi_pkg::GUARD_BITS - 1))) >> bsi_pkg::GUARD_BITS;
		return (r > bsi_pkg::INFO_MAX) ? bsi_pkg::INFO_MAX : r[bsi_pkg::INFO_BITS-1:0];
	endfunction

	task automatic predict(input bsi_pkg::cmd_t c, input logic [7:0] b);
		symbol_info_t e;
		int unsigned  s;
		int unsigned  t;
		case (c)
			bsi_pkg::CMD_ADD: begin
				if (b != 0 && total != {CNT_W{1'b1}}) begin
					counts[b]++;
					total++;
				end
			end
			bsi_pkg::CMD_CLEAR: begin
				foreach (counts[i])
					counts[i] = '0;
				total = '0;
				cursor = 0;
			end
			bsi_pkg::CMD_READ: begin
				s = cursor;
				while (s < bsi_pkg::SYMBOLS && counts[s] == 0)
					s++;
				if (s >= bsi_pkg::SYMBOLS) begin
					cursor = bsi_pkg::SYMBOLS;
					e = '{8'd0, '0, 1'b0, 1'b1};
				end else begin
					t = s + 1;
					while (t < bsi_pkg::SYMBOLS && counts[t] == 0)
						t++;
					e = '{s[7:0], info_of(counts[s]), t >= bsi_pkg::SYMBOLS, 1'b0};
					cursor = s + 1;
				end
				info_q.push_back(e);
			end
			default: ;
		endcase
	endtask

	initial begin
		foreach (counts[i])
			counts[i] = '0;
		total = '0;
		cursor = 0;
		errors = 0;
	end

	always @(posedge clk) begin
		symbol_info_t e;
		if (arst_n && results.valid && results.ready) begin
			if (info_q.size() == 0) begin
				$display("%0t: unexpected transfer: symbol %h info %h", $realtime,
					results.symbol, results.surprisal);
				errors++;
			end else begin
				e = info_q.pop_front();
				if (results.symbol !== e.symbol || results.surprisal !== e.info
						|| results.is_last !== e.is_last
						|| results.none_left !== e.none_left) begin
					$display("%0t: mismatch expected sym %h info %h last %b none %b",
						$realtime, e.symbol, e.info, e.is_last, e.none_left);
					$display("%0t:          actual sym %h info %h last %b none %b",
						$realtime, results.symbol, results.surprisal,
						results.is_last, results.none_left);
					errors++;
				end
			end
		end
		if (arst_n && items.valid && items.ready)
			predict(bsi_pkg::cmd_t'(items.command), items.symbol_byte);
		outstanding = info_q.size();
	end
endmodule

@@ verif/tb_byte_self_information.sv @@
`timescale 1ns / 100ps
module tb_byte_self_information;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle;
	int   snk_idle;
	int   errors;
	int   outstanding;
	int   quiet;

	bsi_in_if  items_if ();
	bsi_out_if results_if ();

	byte_self_information u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	bsi_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items_if),
		.results     (results_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			results_if.ready <= 1'b0;
		else
			results_if.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("** byte_self_information: FAILED **");
			$finish;
		end
	end

	task automatic send(input bsi_pkg::cmd_t c, input logic [7:0] b);
		if ($urandom_range(99) < src_idle) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle)
				@(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.command <= c;
		items_if.symbol_byte <= b;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int         sent;
		int         k;
		int         r;
		int         alpha;
		logic [7:0] pool[6];
		sent = 0;
		while (sent < n) begin
			k = $urandom_range(99);
			if (k < 70) begin
				alpha = $urandom_range(1, 6);
				foreach (pool[i])
					pool[i] = 8'($urandom_range(255));
				k = $urandom_range(1, 12);
				repeat (k)
					send(bsi_pkg::CMD_ADD, pool[$urandom_range(alpha - 1)]);
				r = $urandom_range(1, alpha + 2);
				repeat (r)
					send(bsi_pkg::CMD_READ, 8'($urandom_range(255)));
				sent += k + r;
			end else if (k < 75) begin
				send(bsi_pkg::CMD_CLEAR, 8'($urandom_range(255)));
				sent++;
			end else begin
				send(bsi_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items_if.valid <= 1'b0;
		items_if.command <= bsi_pkg::CMD_NOP;
		items_if.symbol_byte <= 8'd0;
		src_idle = 7;
		snk_idle = 61;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(bsi_pkg::CMD_ADD, 8'd0);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_ADD, 8'd1);
		send(bsi_pkg::CMD_ADD, 8'd255);
		send(bsi_pkg::CMD_ADD, 8'd255);
		send(bsi_pkg::CMD_READ, 8'hff);
		send(bsi_pkg::CMD_NOP, 8'hff);
		send(bsi_pkg::CMD_ADD, 8'd128);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_ADD, 8'd2);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_CLEAR, 8'd0);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_ADD, 8'd5);
		send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_CLEAR, 8'd0);

		// skewed counts over two symbols, then read past the end
		for (int i = 0; i < 60; i++)
			send(bsi_pkg::CMD_ADD, (i % 3 == 0) ? 8'd7 : 8'd200);
		repeat (3)
			send(bsi_pkg::CMD_READ, 8'd0);
		send(bsi_pkg::CMD_CLEAR, 8'd0);
		drain();

		random_phase(300);
		drain();
		src_idle = 61;
		snk_idle = 7;
		random_phase(300);
		drain();
		src_idle = 0;
		snk_idle = 0;
		random_phase(320);
		drain();
		repeat (800) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("** byte_self_information: PASSED **");
		else
			$display("** byte_self_information: FAILED **");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/bsi_pkg.sv
src/bsi_in_if.sv
src/bsi_out_if.sv
src/bsi_hist_mem.sv
src/bsi_log2.sv
src/byte_self_information.sv
verif/bsi_checker.sv
verif/tb_byte_self_information.sv
